### src/basin_pour_point_table_core_assert.svh
// Assertion macros of the pour point table RTL.
`ifndef BASIN_POUR_POINT_TABLE_CORE_ASSERT_SVH
`define BASIN_POUR_POINT_TABLE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BPPT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BPPT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/bppt_pkg.sv
// Shared types, constants and state codes of the pour point table.
package bppt_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int TABLE_DEPTH = 2048;

  localparam int COL_W  = $clog2(MAX_WIDTH);        // line store address
  localparam int CNT_W  = $clog2(MAX_WIDTH + 1);    // column counter, holds the width
  localparam int TBL_AW = $clog2(TABLE_DEPTH);      // table address
  localparam int TCNT_W = $clog2(TABLE_DEPTH + 1);  // fill count
  localparam int PIX_W  = 48;                       // label + elevation

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam logic REG_LINE_WIDTH = 1'b0;
  localparam logic REG_LINE_COUNT = 1'b1;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] basin_label;
    logic signed [31:0] elevation;
    logic [10:0]        entry_index;
  } in_item_t;

  typedef struct packed {
    logic               entry_valid;
    logic signed [15:0] small_label;
    logic signed [15:0] big_label;
    logic signed [31:0] small_side_elev;
    logic signed [31:0] big_side_elev;
    logic [15:0]        entry_line;
    logic [11:0]        entry_count;
    logic               overflow;
    logic               scan_done;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    logic signed [31:0] se;
    logic signed [31:0] be;
    logic [15:0]        line;
  } pair_t;

  typedef struct packed {
    logic clr_step;
    logic take_pix;
    logic take_rd;
    logic out_load;
    logic scan_start;
    logic col_rd;
    logic col_shift;
    logic col_next;
    logic upd_start;
    logic upd_next;
    logic srch_start;
    logic srch_rd;
    logic srch_next;
    logic tbl_wr;
    logic set_full;
  } cmd_t;

  typedef struct packed {
    logic              clr_done;
    logic              scan_pend;
    logic              center_hit;
    logic              col_last;
    logic              k_skip;
    logic              k_last;
    logic              full;
    logic              srch_end;
    logic              srch_match;
    logic              better;
    logic              room;
    logic              out_free;
    logic [TCNT_W-1:0] total;
  } stat_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_TBL_OUT,
    ST_SCAN_START,
    ST_COL_RD,
    ST_COL_SH,
    ST_COL_EVAL,
    ST_COL_NEXT,
    ST_UPD,
    ST_SRCH,
    ST_SRCH_CMP,
    ST_UPD_NEXT
  } st_t;

endpackage

### src/bppt_ctrl.sv
// Sequencer: line store clear, item intake, window sweep and pair table search.
module bppt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_kind,
  input  bppt_pkg::stat_t stat,
  output bppt_pkg::cmd_t  cmd,
  output logic            in_stall
);
  import bppt_pkg::*;

  st_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_kind == KIND_READ) begin
            cmd.take_rd = 1'b1;
            state_nxt   = ST_TBL_OUT;
          end else begin
            cmd.take_pix = 1'b1;
            state_nxt    = ST_SCAN_START;
          end
        end
      end
      ST_TBL_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_SCAN_START: begin
        if (stat.scan_pend) begin
          cmd.scan_start = 1'b1;
          state_nxt      = ST_COL_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_COL_RD: begin
        cmd.col_rd = 1'b1;
        state_nxt  = ST_COL_SH;
      end
      ST_COL_SH: begin
        cmd.col_shift = 1'b1;
        state_nxt     = ST_COL_EVAL;
      end
      ST_COL_EVAL: begin
        if (stat.center_hit && !stat.full) begin
          cmd.upd_start = 1'b1;
          state_nxt     = ST_UPD;
        end else begin
          state_nxt = ST_COL_NEXT;
        end
      end
      ST_COL_NEXT: begin
        if (stat.col_last) begin
          state_nxt = ST_SCAN_START;
        end else begin
          cmd.col_next = 1'b1;
          state_nxt    = ST_COL_RD;
        end
      end
      ST_UPD: begin
        if (stat.full) begin
          state_nxt = ST_COL_NEXT;
        end else if (stat.k_skip) begin
          state_nxt = ST_UPD_NEXT;
        end else begin
          cmd.srch_start = 1'b1;
          state_nxt      = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (stat.srch_end) begin
          if (stat.room) cmd.tbl_wr   = 1'b1;
          else           cmd.set_full = 1'b1;
          state_nxt = ST_UPD_NEXT;
        end else begin
          cmd.srch_rd = 1'b1;
          state_nxt   = ST_SRCH_CMP;
        end
      end
      ST_SRCH_CMP: begin
        if (stat.srch_match) begin
          if (stat.better) cmd.tbl_wr = 1'b1;
          state_nxt = ST_UPD_NEXT;
        end else begin
          cmd.srch_next = 1'b1;
          state_nxt     = ST_SRCH;
        end
      end
      ST_UPD_NEXT: begin
        if (stat.k_last) begin
          state_nxt = ST_COL_NEXT;
        end else begin
          cmd.upd_next = 1'b1;
          state_nxt    = ST_UPD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### src/bppt_dp.sv
// Datapath: line stores, 3x3 window, pair table memory and output register.
module bppt_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  bppt_pkg::cmd_t      cmd,
  input  bppt_pkg::in_item_t  in_data,
  input  logic [12:0]         line_width,
  input  logic [14:0]         line_count,
  input  logic                out_stall,
  output bppt_pkg::stat_t     stat,
  output logic                out_valid,
  output bppt_pkg::out_item_t out_data
);
  import bppt_pkg::*;

  function automatic logic [16:0] mag17(input logic signed [15:0] v);
    logic signed [16:0] x;
    x = {v[15], v};
    return x[16] ? 17'(-x) : 17'(x);
  endfunction

  // ---- control / counters
  logic [COL_W-1:0]  clr_cnt_r;
  logic [CNT_W-1:0]  col_r;
  logic [15:0]       row_r;
  logic [1:0]        rot_r, srot_r;
  logic              pend_a_r, pend_b_r;
  logic [1:0]        bank_r [3];   // above, center, below; 3 = zero row
  logic [15:0]       line_r;
  logic [CNT_W-1:0]  j_r;
  logic signed [15:0] nb_lab_r [9];
  logic signed [31:0] nb_elv_r [9];
  logic [3:0]        k_r;
  logic [TCNT_W-1:0] i_r, total_r;
  logic              full_r, rd_ok_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic [CNT_W-1:0]  w;
  logic              scan_done;
  logic [CNT_W-1:0]  col_inc;

  always_comb begin
    if (line_width == 13'd0)                    w = CNT_W'(1);
    else if (32'(line_width) > 32'(MAX_WIDTH))  w = CNT_W'(MAX_WIDTH);
    else                                        w = CNT_W'(line_width);
  end

  assign scan_done = (row_r >= {1'b0, line_count});
  assign col_inc   = col_r + CNT_W'(1);

  // ---- line stores
  logic [COL_W-1:0] bank_addr;
  logic [PIX_W-1:0] bank_wdata;
  logic [2:0]       bank_we;
  logic [PIX_W-1:0] bank_q [3];
  logic             pix_store;

  assign pix_store = cmd.take_pix && !scan_done && (col_r < w);

  always_comb begin
    bank_we    = 3'b000;
    bank_wdata = {in_data.basin_label, in_data.elevation};
    bank_addr  = j_r[COL_W-1:0];
    if (cmd.clr_step) begin
      bank_we    = 3'b111;
      bank_wdata = '0;
      bank_addr  = clr_cnt_r;
    end else if (cmd.take_pix) begin
      bank_addr = col_r[COL_W-1:0];
      if (pix_store) bank_we = 3'b001 << rot_r;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_bank
    logic [PIX_W-1:0] mem [MAX_WIDTH];
    always_ff @(posedge clk) begin
      if (bank_we[g]) mem[bank_addr] <= bank_wdata;
      bank_q[g] <= mem[bank_addr];
    end
  end

  // new window column, one value per row, zero outside the raster
  logic signed [15:0] new_lab [3];
  logic signed [31:0] new_elv [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      new_lab[r] = '0;
      new_elv[r] = '0;
      if (j_r < w) begin
        case (bank_r[r])
          2'd0: {new_lab[r], new_elv[r]} = bank_q[0];
          2'd1: {new_lab[r], new_elv[r]} = bank_q[1];
          2'd2: {new_lab[r], new_elv[r]} = bank_q[2];
          default: begin
            new_lab[r] = '0;
            new_elv[r] = '0;
          end
        endcase
      end
    end
  end

  // ---- neighbour selection and pair values
  logic               differs;
  logic [16:0]        a5;
  logic signed [15:0] m1, m2, lo, hi;
  logic signed [31:0] e1, e2, se, be, max_new, max_old;
  logic [15:0]        l1, lsel;
  logic               m1_lo;
  pair_t              tbl_q, pair_wr;

  always_comb begin
    a5 = mag17(nb_lab_r[4]);
    differs = 1'b0;
    for (int k = 0; k < 9; k++) begin
      if (mag17(nb_lab_r[k]) != a5) differs = 1'b1;
    end
  end

  always_comb begin
    m1 = nb_lab_r[k_r];
    e1 = nb_elv_r[k_r];
    m2 = nb_lab_r[4];
    e2 = nb_elv_r[4];
    if (k_r < 4'd3)      l1 = line_r - 16'd1;
    else if (k_r > 4'd5) l1 = line_r + 16'd1;
    else                 l1 = line_r;
    m1_lo   = (m1 < m2);
    lo      = m1_lo ? m1 : m2;
    hi      = m1_lo ? m2 : m1;
    se      = m1_lo ? e1 : e2;
    be      = m1_lo ? e2 : e1;
    lsel    = m1_lo ? l1 : line_r;
    max_new = (e1 > e2) ? e1 : e2;
    max_old = (tbl_q.se > tbl_q.be) ? tbl_q.se : tbl_q.be;
    pair_wr = '{lo: lo, hi: hi, se: se, be: be, line: lsel};
  end

  // ---- pair table
  pair_t             tbl_mem [TABLE_DEPTH];
  logic [TBL_AW-1:0] tbl_addr;

  assign tbl_addr = cmd.take_rd ? TBL_AW'(in_data.entry_index) : i_r[TBL_AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.tbl_wr) tbl_mem[tbl_addr] <= pair_wr;
    if (cmd.take_rd || cmd.srch_rd) tbl_q <= tbl_mem[tbl_addr];
  end

  // ---- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      col_r       <= '0;
      row_r       <= '0;
      rot_r       <= '0;
      pend_a_r    <= 1'b0;
      pend_b_r    <= 1'b0;
      total_r     <= '0;
      full_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + COL_W'(1);
      if (cmd.take_pix && !scan_done) begin
        if (col_inc >= w) begin
          col_r    <= '0;
          row_r    <= row_r + 16'd1;
          pend_a_r <= (row_r + 16'd1 >= 16'd2);
          pend_b_r <= (row_r + 16'd1 >= {1'b0, line_count});
          rot_r    <= (rot_r == 2'd2) ? 2'd0 : rot_r + 2'd1;
        end else begin
          col_r <= col_inc;
        end
      end
      if (cmd.scan_start) begin
        if (pend_a_r) pend_a_r <= 1'b0;
        else          pend_b_r <= 1'b0;
      end
      if (cmd.tbl_wr && (i_r >= total_r)) total_r <= total_r + TCNT_W'(1);
      if (cmd.set_full) full_r <= 1'b1;
      if (cmd.out_load)                  out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  // ---- payload registers
  always_ff @(posedge clk) begin
    if (cmd.take_pix && !scan_done && (col_inc >= w)) srot_r <= rot_r;
    if (cmd.scan_start) begin
      j_r <= '0;
      for (int n = 0; n < 9; n++) begin
        nb_lab_r[n] <= '0;
        nb_elv_r[n] <= '0;
      end
      if (pend_a_r) begin
        bank_r[0] <= (srot_r == 2'd2) ? 2'd0 : srot_r + 2'd1;
        bank_r[1] <= (srot_r == 2'd0) ? 2'd2 : srot_r - 2'd1;
        bank_r[2] <= srot_r;
        line_r    <= row_r - 16'd1;
      end else begin
        bank_r[0] <= (srot_r == 2'd0) ? 2'd2 : srot_r - 2'd1;
        bank_r[1] <= srot_r;
        bank_r[2] <= 2'd3;
        line_r    <= row_r;
      end
    end
    if (cmd.col_shift) begin
      for (int r = 0; r < 3; r++) begin
        nb_lab_r[r*3]   <= nb_lab_r[r*3+1];
        nb_lab_r[r*3+1] <= nb_lab_r[r*3+2];
        nb_lab_r[r*3+2] <= new_lab[r];
        nb_elv_r[r*3]   <= nb_elv_r[r*3+1];
        nb_elv_r[r*3+1] <= nb_elv_r[r*3+2];
        nb_elv_r[r*3+2] <= new_elv[r];
      end
    end
    if (cmd.col_next) j_r <= j_r + CNT_W'(1);
    if (cmd.upd_start) k_r <= '0;
    if (cmd.upd_next)  k_r <= k_r + 4'd1;
    if (cmd.srch_start) i_r <= '0;
    if (cmd.srch_next)  i_r <= i_r + TCNT_W'(1);
    if (cmd.take_rd) begin
      rd_ok_r <= (32'(in_data.entry_index) < 32'(total_r)) &&
                 (32'(in_data.entry_index) < 32'(TABLE_DEPTH));
    end
    if (cmd.out_load) begin
      out_data_r.entry_valid     <= rd_ok_r;
      out_data_r.small_label     <= rd_ok_r ? tbl_q.lo   : '0;
      out_data_r.big_label       <= rd_ok_r ? tbl_q.hi   : '0;
      out_data_r.small_side_elev <= rd_ok_r ? tbl_q.se   : '0;
      out_data_r.big_side_elev   <= rd_ok_r ? tbl_q.be   : '0;
      out_data_r.entry_line      <= rd_ok_r ? tbl_q.line : '0;
      out_data_r.entry_count     <= 12'(total_r);
      out_data_r.overflow        <= full_r;
      out_data_r.scan_done       <= scan_done;
    end
  end

  // ---- status
  always_comb begin
    stat.clr_done   = (clr_cnt_r == COL_W'(MAX_WIDTH - 1));
    stat.scan_pend  = pend_a_r || pend_b_r;
    stat.center_hit = (j_r != '0) && (nb_lab_r[4] != '0) && differs;
    stat.col_last   = (j_r >= w);
    stat.k_skip     = (m1 == m2);
    stat.k_last     = (k_r == 4'd8);
    stat.full       = full_r;
    stat.srch_end   = (i_r >= total_r);
    stat.srch_match = (tbl_q.lo == lo) && (tbl_q.hi == hi);
    stat.better     = (max_new < max_old);
    stat.room       = (32'(total_r) < 32'(TABLE_DEPTH));
    stat.out_free   = !out_valid_r || !out_stall;
    stat.total      = total_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### src/basin_pour_point_table_core.sv
// Top level of the pour point table: config registers, sequencer and datapath.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------
//  in_     | to block  | in_valid / in_stall     | in_item_t (pixel or read)
//  out_    | from block| out_valid / out_stall   | out_item_t (table entry)
//  apb     | to block  | psel/penable/pready     | line_width @0, line_count @4
//
//  After reset a clearing pass zeroes the three line stores with in_stall high.
//  A pixel that does not end a line passes ST_SCAN_START; a table read passes ST_TBL_OUT plus
//  any wait for the output register. No new item is taken until the block is idle again.
//  A line end sweeps up to two lines: a start state per line, read, shift, evaluate and next
//  states per column, update and update-next states per neighbor, search and compare states
//  per table entry searched (the single-port table memory sets this), and the append at the end.
//  An output stall holds a pending read and all intake behind it; pixels keep flowing behind a loaded result.
`include "basin_pour_point_table_core_assert.svh"

module basin_pour_point_table_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bppt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bppt_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import bppt_pkg::*;

  logic [12:0] line_width_r;
  logic [14:0] line_count_r;
  logic        cfg_wr;

  cmd_t  cmd;
  stat_t stat;

  // config registers; word index from paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= 13'd1;
      line_count_r <= 15'd1;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_LINE_WIDTH: line_width_r <= pwdata[12:0];
        REG_LINE_COUNT: line_count_r <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_LINE_COUNT) ? 32'(line_count_r) : 32'(line_width_r);

  // sequencer
  bppt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .stat     (stat),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // line stores, window, table and output register
  bppt_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_data    (in_data),
    .line_width (line_width_r),
    .line_count (line_count_r),
    .out_stall  (out_stall),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

  // overflow only once every slot is taken
  `BPPT_ASSERT_IMP(a_full_at_depth, stat.full, stat.total == TCNT_W'(TABLE_DEPTH), "overflow with room left")
  // intake only with no line sweep owed
  `BPPT_ASSERT_IMP(a_idle_no_scan, !in_stall, !stat.scan_pend, "intake while a sweep is pending")
  // an append grows the fill count by exactly one
  `BPPT_ASSERT_NXT(a_append_count, cmd.tbl_wr && stat.srch_end, stat.total == $past(stat.total) + TCNT_W'(1), "append count slip")

endmodule

### verif/basin_pour_point_table_core_tb.sv
// Self-checking testbench of the pour point table: random raster scans, table reads, APB setup.
`timescale 1ns / 1ps

module basin_pour_point_table_core_tb;
  import bppt_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000000;  // idle cycles; covers the store clear and long sweeps
  localparam int HOLD_CYCLES    = 400;      // long receiver hold-off

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  basin_pour_point_table_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predicted block state: line stores, pair table, counters and registers.
  // ---------------------------------------------------------------------------
  int          lab_store [3*MAX_WIDTH];
  int          elev_store[3*MAX_WIDTH];
  int          pair_lo [TABLE_DEPTH];
  int          pair_hi [TABLE_DEPTH];
  int          pair_se [TABLE_DEPTH];
  int          pair_be [TABLE_DEPTH];
  int unsigned pair_ln [TABLE_DEPTH];
  int unsigned pairs_filled;
  bit          pairs_full;
  int unsigned lines_in;     // complete lines received
  int unsigned col_pos;
  int unsigned bank_in;      // bank taking the incoming line
  int unsigned width_reg = 1;
  int unsigned count_reg = 1;

  in_item_t  pending_items[$];   // items waiting for the driver
  out_item_t entry_reads[$];     // expected table read results

  int errors = 0;
  int pixels_taken = 0;
  int reads_taken = 0;
  int reads_checked = 0;
  int quiet = 0;                 // no random idling on either side while set
  int hold_asks = 0;             // long hold-off requests from the sequence
  int hold_done = 0;
  int hold_left = 0;
  int rcv_left = 0;
  int send_gap = 0;
  int idle_cycles = 0;

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  function automatic int imax(int a, int b);
    return (a > b) ? a : b;
  endfunction

  function automatic int iabs(int a);
    return (a < 0) ? -a : a;
  endfunction

  // Insert a basin pair, or lower its pour point when the new crest is lower.
  function automatic void pair_merge(int m1, int m2, int e1, int e2,
                                     int unsigned l1, int unsigned l2);
    int lo, hi;
    int unsigned i;
    if (m1 == m2 || pairs_full) return;
    lo = (m1 < m2) ? m1 : m2;
    hi = (m1 > m2) ? m1 : m2;
    i = 0;
    while (i < pairs_filled && !(pair_lo[i] == lo && pair_hi[i] == hi)) i++;
    if (i < pairs_filled) begin
      if (imax(e1, e2) >= imax(pair_se[i], pair_be[i])) return;
    end else if (pairs_filled < TABLE_DEPTH) begin
      pairs_filled++;
      pair_lo[i] = lo;
      pair_hi[i] = hi;
    end else begin
      pairs_full = 1'b1;
      return;
    end
    if (m1 == lo) begin
      pair_se[i] = e1; pair_be[i] = e2; pair_ln[i] = l1;
    end else begin
      pair_se[i] = e2; pair_be[i] = e1; pair_ln[i] = l2;
    end
  endfunction

  // Sweep one line; banks above / center / below, bank 3 is zero padding.
  function automatic void sweep_line(int unsigned ba, int unsigned bc, int unsigned bb,
                                     int unsigned line, int unsigned w);
    int m[9];
    int e[9];
    int unsigned bk[3];
    int col, a5;
    bit differs;
    bk[0] = ba; bk[1] = bc; bk[2] = bb;
    for (int unsigned c = 0; c < w; c++) begin
      if (lab_store[bc*MAX_WIDTH + c] != 0) begin
        for (int k = 0; k < 9; k++) begin
          col = int'(c) + (k % 3) - 1;
          m[k] = 0; e[k] = 0;
          if (bk[k/3] < 3 && col >= 0 && col < int'(w)) begin
            m[k] = lab_store[bk[k/3]*MAX_WIDTH + col];
            e[k] = elev_store[bk[k/3]*MAX_WIDTH + col];
          end
        end
        a5 = iabs(m[4]);
        differs = 1'b0;
        for (int k = 0; k < 9; k++) if (iabs(m[k]) != a5) differs = 1'b1;
        if (differs)
          for (int k = 0; k < 9 && !pairs_full; k++)
            pair_merge(m[k], m[4], e[k], e[4], line + (k / 3) - 1, line);
      end
    end
  endfunction

  function automatic void take_pixel(in_item_t it);
    int unsigned w, rot;
    if (lines_in >= count_reg) return;   // scan already done
    w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
    rot = bank_in;
    if (col_pos < w) begin
      lab_store[rot*MAX_WIDTH + col_pos]  = 32'(it.basin_label);
      elev_store[rot*MAX_WIDTH + col_pos] = it.elevation;
    end
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      lines_in++;
      if (lines_in >= 2) sweep_line((rot+1)%3, (rot+2)%3, rot, lines_in - 1, w);
      if (lines_in >= count_reg) sweep_line((rot+2)%3, rot, 3, lines_in, w);
      bank_in = (rot + 1) % 3;
    end
  endfunction

  function automatic out_item_t read_entry(in_item_t it);
    out_item_t r;
    int unsigned idx;
    idx = 32'(it.entry_index);
    r = '0;
    if (idx < pairs_filled) begin
      r.entry_valid     = 1'b1;
      r.small_label     = 16'(pair_lo[idx]);
      r.big_label       = 16'(pair_hi[idx]);
      r.small_side_elev = pair_se[idx];
      r.big_side_elev   = pair_be[idx];
      r.entry_line      = 16'(pair_ln[idx]);
    end
    r.entry_count = 12'(pairs_filled);
    r.overflow    = pairs_full;
    r.scan_done   = (lines_in >= count_reg);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued items, updates the prediction on each accept.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (in_data.kind == KIND_PIXEL) begin
          take_pixel(in_data);
          pixels_taken++;
        end else begin
          entry_reads.push_back(read_entry(in_data));
          reads_taken++;
        end
      end
      if (in_valid && in_stall) begin
        // payload holds while stalled
      end else if (send_gap > 0 && !quiet) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_data  <= pending_items.pop_front();
        in_valid <= 1'b1;
        send_gap <= draw_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random stall, one long hold-off on request, field checks.
  // ---------------------------------------------------------------------------
  task automatic field_chk(string nm, longint unsigned e, longint unsigned a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, nm, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (entry_reads.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0h", $time, out_data);
          errors++;
        end else begin
          want = entry_reads.pop_front();
          reads_checked++;
          field_chk("entry_valid", want.entry_valid, out_data.entry_valid);
          field_chk("small_label", want.small_label, out_data.small_label);
          field_chk("big_label", want.big_label, out_data.big_label);
          field_chk("small_side_elev", want.small_side_elev, out_data.small_side_elev);
          field_chk("big_side_elev", want.big_side_elev, out_data.big_side_elev);
          field_chk("entry_line", want.entry_line, out_data.entry_line);
          field_chk("entry_count", want.entry_count, out_data.entry_count);
          field_chk("overflow", want.overflow, out_data.overflow);
          field_chk("scan_done", want.scan_done, out_data.scan_done);
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (hold_asks != hold_done) begin
        hold_done <= hold_asks;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (rcv_left > 0 && !quiet) begin
        rcv_left  <= rcv_left - 1;
        out_stall <= 1'b1;
      end else begin
        rcv_left  <= draw_gap();
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: ends the run if no item moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, entry_reads.size());
      $display("basin_pour_point_table_core_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence helpers
  // ---------------------------------------------------------------------------
  function automatic in_item_t mk_pixel(int lab, int elev);
    in_item_t it;
    it = '0;
    it.kind        = KIND_PIXEL;
    it.basin_label = 16'(lab);
    it.elevation   = elev;
    it.entry_index = 11'($urandom);   // don't care for pixels, toggled anyway
    return it;
  endfunction

  function automatic in_item_t mk_read(int unsigned idx);
    in_item_t it;
    it = '0;
    it.kind        = KIND_READ;
    it.basin_label = 16'($urandom);
    it.elevation   = $urandom;
    it.entry_index = 11'(idx);
    return it;
  endfunction

  // Block is idle once a trailing read comes back (it queues behind any sweep).
  task automatic settle();
    pending_items.push_back(mk_read(0));
    while (pending_items.size() != 0 || in_valid || entry_reads.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic reg_write(logic regsel, int unsigned val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {regsel, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (regsel == REG_LINE_WIDTH) width_reg = val & 32'h1FFF;
    else count_reg = val & 32'h7FFF;
  endtask

  // Labels come from a small pool so the pair table stays short (search cost).
  function automatic int pick_label();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 0;
    if (r < 30) return 1;
    if (r < 40) return -1;
    if (r < 55) return 2;
    if (r < 65) return -3;
    if (r < 75) return 5;
    if (r < 83) return 32767;
    if (r < 91) return -32768;
    if (r < 98) return 7;
    return $urandom_range(8, 40);
  endfunction

  // One raster scan of w x nl with reads sprinkled in and stray pixels after it.
  task automatic scan_phase(int unsigned w, int unsigned nl);
    int lab;
    settle();
    reg_write(REG_LINE_WIDTH, w);
    reg_write(REG_LINE_COUNT, lines_in + nl);
    lab = pick_label();
    for (int unsigned n = 0; n < w*nl + 2; n++) begin
      if ($urandom_range(0, 99) < 40) lab = pick_label();
      pending_items.push_back(mk_pixel(lab, $urandom));
      if ($urandom_range(0, 99) < 12)
        pending_items.push_back(mk_read($urandom_range(0, 99) < 85 ?
                                        $urandom_range(0, pairs_filled + 4) :
                                        $urandom_range(0, 2047)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int phases;
    phases = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset config: one-pixel scan, then pixels after it are ignored.
    pending_items.push_back(mk_pixel(1, 32'sh100));
    pending_items.push_back(mk_pixel(2, 32'sh200));
    pending_items.push_back(mk_read(0));

    // 3x3 with label and elevation extremes, mixed signs of one magnitude.
    settle();
    reg_write(REG_LINE_WIDTH, 3);
    reg_write(REG_LINE_COUNT, lines_in + 3);
    pending_items.push_back(mk_pixel(-32768, 32'h7FFFFFFF));
    pending_items.push_back(mk_pixel(32767, 32'h80000000));
    pending_items.push_back(mk_pixel(0, 0));
    pending_items.push_back(mk_pixel(1, -256));
    pending_items.push_back(mk_pixel(-1, 512));
    pending_items.push_back(mk_pixel(32767, 32'h7FFFFFFF));
    pending_items.push_back(mk_pixel(2, 32'h80000000));
    pending_items.push_back(mk_pixel(-32768, 1));
    pending_items.push_back(mk_pixel(2, -1));
    // Filled, unfilled and last index.
    pending_items.push_back(mk_read(0));
    pending_items.push_back(mk_read(3));
    pending_items.push_back(mk_read(100));
    pending_items.push_back(mk_read(2047));

    // Width register zero (taken as one) and above the maximum (clamped).
    settle();
    reg_write(REG_LINE_WIDTH, 0);
    reg_write(REG_LINE_COUNT, lines_in + 4);
    pending_items.push_back(mk_pixel(5, 10));
    pending_items.push_back(mk_pixel(7, 20));
    settle();
    reg_write(REG_LINE_WIDTH, 13'h1FFF);
    pending_items.push_back(mk_pixel(5, -10));
    pending_items.push_back(mk_pixel(7, -20));
    pending_items.push_back(mk_pixel(3, 30));
    // Shrink width mid-line: next pixel lands past the end and closes the line.
    settle();
    reg_write(REG_LINE_WIDTH, 2);
    pending_items.push_back(mk_pixel(9, 40));
    pending_items.push_back(mk_pixel(5, 50));
    pending_items.push_back(mk_pixel(7, 60));
    pending_items.push_back(mk_read(pairs_filled));

    // Random scans; a few quiet stretches and one long receiver hold-off.
    while (pixels_taken + reads_taken + pending_items.size() < 1500) begin
      phases++;
      quiet = ($urandom_range(0, 5) == 0);
      if (phases == 4) begin
        settle();
        quiet = 1;
        hold_asks++;
        repeat (30) pending_items.push_back(mk_read($urandom_range(0, pairs_filled)));
      end
      scan_phase($urandom_range(0, 9) == 0 ? $urandom_range(13, 24) : $urandom_range(1, 12),
                 $urandom_range(1, 6));
    end

    // Line count extreme: scan never completes.
    settle();
    quiet = 0;
    reg_write(REG_LINE_WIDTH, 4);
    reg_write(REG_LINE_COUNT, 32767);
    repeat (12) pending_items.push_back(mk_pixel(pick_label(), $urandom));
    pending_items.push_back(mk_read(0));

    while (pending_items.size() != 0 || in_valid || entry_reads.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("Covered %0d pixels over %0d random scans and %0d table reads (%0d checked).",
             pixels_taken, phases, reads_taken, reads_checked);
    $display("Pair table ended with %0d entries after %0d lines.", pairs_filled, lines_in);
    if (errors == 0 && entry_reads.size() == 0)
      $display("basin_pour_point_table_core_tb OK");
    else
      $display("basin_pour_point_table_core_tb NOT OK");
    $finish;
  end

endmodule

### files.f
+incdir+src
src/bppt_pkg.sv
src/bppt_ctrl.sv
src/bppt_dp.sv
src/basin_pour_point_table_core.sv
verif/basin_pour_point_table_core_tb.sv
